// ----- src/rtbu_pkg.sv -----
// ----------------------------------------------------------------------------
// rtbu_pkg
// Shared types and constants of the retransmission table with backoff.
// ----------------------------------------------------------------------------
package rtbu_pkg;

  localparam int unsigned DELAY_COUNT = 5;
  localparam int unsigned DELAY_W     = 8;
  localparam int unsigned RETRY_W     = 3;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned RESULT_W    = 3;
  localparam int unsigned IN_TDATA_W  = 168;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DELAY_FIRST  = 3'd0;
  localparam logic [2:0] REG_DELAY_SECOND = 3'd1;
  localparam logic [2:0] REG_DELAY_THIRD  = 3'd2;
  localparam logic [2:0] REG_DELAY_FOURTH = 3'd3;
  localparam logic [2:0] REG_DELAY_FIFTH  = 3'd4;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT = RETRY_W'(DELAY_COUNT);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_TICK   = 3'd2,
    ACT_FOUND  = 3'd3,
    ACT_LOST   = 3'd4,
    ACT_FLUSH  = 3'd5
  } action_e;

  typedef enum logic [RESULT_W-1:0] {
    RES_OK       = 3'd0,
    RES_NOTFOUND = 3'd1,
    RES_FULL     = 3'd2,
    RES_RESEND   = 3'd3,
    RES_GIVEUP   = 3'd4
  } result_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_FINISH
  } state_e;

  typedef logic [DELAY_COUNT-1:0][DELAY_W-1:0] delays_t;

  // One table entry as held in the data memory.
  typedef struct packed {
    logic [15:0] packet;
    logic [15:0] reply_port;
    logic [31:0] reply_addr;
    logic [3:0]  kind;
    logic [63:0] uid_time;
    logic [31:0] uid_addr;
  } entry_t;

  // Backoff state of one entry as held in the timer memory.
  typedef struct packed {
    logic [RETRY_W-1:0] retries;
    logic [DELAY_W-1:0] ticks;
  } tmr_t;

  // Delay that follows the given number of retransmissions.
  function automatic logic [DELAY_W-1:0] delay_sel(delays_t d, logic [RETRY_W-1:0] r);
    logic [DELAY_W-1:0] v;
    v = d[0];
    case (r)
      3'd1:    v = d[1];
      3'd2:    v = d[2];
      3'd3:    v = d[3];
      3'd4:    v = d[4];
      default: v = d[0];
    endcase
    return v;
  endfunction

endpackage

// ----- src/retransmit_table_with_backoff_unit.sv -----
// ----------------------------------------------------------------------------
// retransmit_table_with_backoff_unit
// Table of unacknowledged messages with a per-entry retransmission backoff.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: action; tdata: message id and add data
// m_axis    out        tuser: result kind; tdata: returned data, occupancy
// apb       in/out     five 8-bit backoff delay registers at 0x00..0x10
//
// Add and remove scan the table, a read state and a process state per slot,
// until a match or the end. Tick and server found always walk every slot
// through the read-modify-write of the timer memory. Server lost, flush and
// unused actions go straight to the finish state without a scan.
// Reset clears the valid and timer-on flags at once; there is no clearing pass.
// A stalled result holds the walk until the previous result has moved on.
// ----------------------------------------------------------------------------
module retransmit_table_with_backoff_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: uid_addr[32], uid_time[64], notice_kind_in[4], reply_addr[32],
  // reply_port[16], packet_ref[16], zero padding.
  input  logic [rtbu_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // action[3]
  input  logic [rtbu_pkg::ACTION_W-1:0]   s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: packet_ref_out[16], notice_kind_out[4], reply_addr_out[32],
  // reply_port_out[16], occupancy, zero padding.
  output logic [((68 + $clog2(TABLE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // result_kind[3]
  output logic [rtbu_pkg::RESULT_W-1:0]   m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned OCC_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_W   = ((68 + OCC_W + 7) / 8) * 8;
  localparam int unsigned ENTRY_W = $bits(rtbu_pkg::entry_t);
  localparam int unsigned TMR_W   = $bits(rtbu_pkg::tmr_t);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TABLE_DEPTH);

  rtbu_pkg::delays_t delays;

  rtbu_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .delays_o (delays)
  );

  // Control state.
  rtbu_pkg::state_e  state_q, state_d;
  rtbu_pkg::action_e op_q, op_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TABLE_DEPTH-1:0] timer_on_q, timer_on_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic                   resend_en_q, resend_en_d;
  logic                   hold_v_q, hold_v_d;
  logic                   out_v_q;

  // Payload of the accepted item.
  rtbu_pkg::entry_t item_q;

  // Result held back until it is known whether it is the last of the step.
  rtbu_pkg::result_e hold_kind_q, hold_kind_d;
  logic [15:0] hold_pkt_q, hold_pkt_d;
  logic [3:0]  hold_nk_q, hold_nk_d;
  logic [31:0] hold_ra_q, hold_ra_d;
  logic [15:0] hold_rp_q, hold_rp_d;

  // Output register.
  rtbu_pkg::result_e out_kind_q;
  logic [15:0]      out_pkt_q;
  logic [3:0]       out_nk_q;
  logic [31:0]      out_ra_q;
  logic [15:0]      out_rp_q;
  logic [OCC_W-1:0] out_occ_q;
  logic             out_last_q;

  logic             push, push_last;
  rtbu_pkg::result_e push_kind;
  logic [15:0]      push_pkt;
  logic [3:0]       push_nk;
  logic [31:0]      push_ra;
  logic [15:0]      push_rp;
  logic             out_free, accept;

  // Memory ports.
  logic             rd_en, d_we, t_we;
  logic [IDX_W-1:0] d_waddr;
  logic [ENTRY_W-1:0] d_rdata;
  logic [TMR_W-1:0]   t_rdata;
  rtbu_pkg::entry_t d_wentry, rd_entry;
  rtbu_pkg::tmr_t   t_wtmr, rd_tmr;

  logic [IDX_W-1:0]          free_idx;
  logic                      uid_hit, slot_live;
  logic [rtbu_pkg::RETRY_W-1:0] retries_nx;

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == rtbu_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_entry        = rtbu_pkg::entry_t'(d_rdata);
  assign rd_tmr          = rtbu_pkg::tmr_t'(t_rdata);
  assign uid_hit         = valid_q[idx_q] && (rd_entry.uid_addr == item_q.uid_addr)
                           && (rd_entry.uid_time == item_q.uid_time);
  assign slot_live       = valid_q[idx_q] && timer_on_q[idx_q];
  assign retries_nx      = rd_tmr.retries + 3'd1;

  // Lowest free slot; only used when the table is not full.
  always_comb begin
    free_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  rtbu_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wentry),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (d_rdata)
  );

  rtbu_ram #(.WIDTH(TMR_W), .DEPTH(TABLE_DEPTH)) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (d_waddr),
    .wdata_i (t_wtmr),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (t_rdata)
  );

  // Sequencer: read a slot, then act on it in the next cycle.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    timer_on_d  = timer_on_q;
    occ_d       = occ_q;
    resend_en_d = resend_en_q;
    hold_v_d    = hold_v_q;
    hold_kind_d = hold_kind_q;
    hold_pkt_d  = hold_pkt_q;
    hold_nk_d   = hold_nk_q;
    hold_ra_d   = hold_ra_q;
    hold_rp_d   = hold_rp_q;
    rd_en       = 1'b0;
    d_we        = 1'b0;
    t_we        = 1'b0;
    d_waddr     = idx_q;
    d_wentry    = item_q;
    t_wtmr      = rd_tmr;
    push        = 1'b0;
    push_last   = 1'b0;
    push_kind   = hold_kind_q;
    push_pkt    = hold_pkt_q;
    push_nk     = hold_nk_q;
    push_ra     = hold_ra_q;
    push_rp     = hold_rp_q;

    case (state_q)
      rtbu_pkg::ST_IDLE: begin
        if (accept) begin
          op_d       = rtbu_pkg::action_e'(s_axis_tuser_i);
          idx_d      = '0;
          hold_v_d   = 1'b0;
          // Returned data fields are zero unless a step fills them in.
          hold_pkt_d = '0;
          hold_nk_d  = '0;
          hold_ra_d  = '0;
          hold_rp_d  = '0;
          case (s_axis_tuser_i)
            rtbu_pkg::ACT_ADD, rtbu_pkg::ACT_REMOVE, rtbu_pkg::ACT_TICK: begin
              state_d = rtbu_pkg::ST_READ;
            end
            rtbu_pkg::ACT_FOUND: begin
              resend_en_d = 1'b1;
              state_d     = rtbu_pkg::ST_READ;
            end
            rtbu_pkg::ACT_LOST: begin
              timer_on_d  = '0;
              resend_en_d = 1'b0;
              state_d     = rtbu_pkg::ST_FINISH;
            end
            rtbu_pkg::ACT_FLUSH: begin
              valid_d    = '0;
              timer_on_d = '0;
              occ_d      = '0;
              state_d    = rtbu_pkg::ST_FINISH;
            end
            default: begin
              state_d = rtbu_pkg::ST_FINISH;
            end
          endcase
        end
      end

      rtbu_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = rtbu_pkg::ST_PROC;
      end

      rtbu_pkg::ST_PROC: begin
        case (op_q)
          rtbu_pkg::ACT_ADD: begin
            if (uid_hit) begin
              hold_v_d    = 1'b1;
              hold_kind_d = rtbu_pkg::RES_OK;
              state_d     = rtbu_pkg::ST_FINISH;
            end else if (idx_q == IDX_LAST) begin
              hold_v_d = 1'b1;
              state_d  = rtbu_pkg::ST_FINISH;
              if (occ_q == OCC_FULL) begin
                hold_kind_d = rtbu_pkg::RES_FULL;
              end else begin
                hold_kind_d          = rtbu_pkg::RES_OK;
                d_waddr              = free_idx;
                d_we                 = 1'b1;
                t_we                 = 1'b1;
                t_wtmr.ticks         = delays[0];
                t_wtmr.retries       = '0;
                valid_d[free_idx]    = 1'b1;
                timer_on_d[free_idx] = resend_en_q;
                occ_d                = occ_q + 1'b1;
              end
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = rtbu_pkg::ST_READ;
            end
          end

          rtbu_pkg::ACT_REMOVE: begin
            if (uid_hit) begin
              hold_v_d          = 1'b1;
              hold_kind_d       = rtbu_pkg::RES_OK;
              hold_nk_d         = rd_entry.kind;
              hold_ra_d         = rd_entry.reply_addr;
              hold_rp_d         = rd_entry.reply_port;
              valid_d[idx_q]    = 1'b0;
              timer_on_d[idx_q] = 1'b0;
              occ_d             = occ_q - 1'b1;
              state_d           = rtbu_pkg::ST_FINISH;
            end else if (idx_q == IDX_LAST) begin
              hold_v_d    = 1'b1;
              hold_kind_d = rtbu_pkg::RES_NOTFOUND;
              state_d     = rtbu_pkg::ST_FINISH;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = rtbu_pkg::ST_READ;
            end
          end

          default: begin
            // Tick and server found: one slot per visit, results may stall it.
            if ((op_q == rtbu_pkg::ACT_TICK) && slot_live
                && (rd_tmr.ticks > 8'd1)) begin
              t_we         = 1'b1;
              t_wtmr.ticks = rd_tmr.ticks - 8'd1;
            end else if (((op_q == rtbu_pkg::ACT_TICK) && slot_live)
                         || ((op_q == rtbu_pkg::ACT_FOUND) && valid_q[idx_q])) begin
              if (hold_v_q && !out_free) begin
                state_d = rtbu_pkg::ST_PROC;
              end else begin
                push     = hold_v_q;
                hold_v_d = 1'b1;
                hold_pkt_d = rd_entry.packet;
                hold_nk_d  = '0;
                hold_ra_d  = '0;
                hold_rp_d  = '0;
                t_we       = 1'b1;
                if (op_q == rtbu_pkg::ACT_FOUND) begin
                  hold_kind_d       = rtbu_pkg::RES_RESEND;
                  t_wtmr.ticks      = delays[0];
                  t_wtmr.retries    = '0;
                  timer_on_d[idx_q] = 1'b1;
                end else if (retries_nx >= rtbu_pkg::RETRY_LIMIT) begin
                  hold_kind_d       = rtbu_pkg::RES_GIVEUP;
                  t_wtmr.retries    = retries_nx;
                  timer_on_d[idx_q] = 1'b0;
                end else begin
                  hold_kind_d    = rtbu_pkg::RES_RESEND;
                  t_wtmr.retries = retries_nx;
                  t_wtmr.ticks   = rtbu_pkg::delay_sel(delays, retries_nx);
                end
              end
            end
            if (!(t_we == 1'b0 && state_d == rtbu_pkg::ST_PROC && hold_v_q && !out_free
                  && (slot_live || op_q == rtbu_pkg::ACT_FOUND))) begin
              if (idx_q == IDX_LAST) begin
                state_d = rtbu_pkg::ST_FINISH;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = rtbu_pkg::ST_READ;
              end
            end
          end
        endcase
      end

      rtbu_pkg::ST_FINISH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!hold_v_q) begin
            push_kind = rtbu_pkg::RES_OK;
            push_pkt  = '0;
            push_nk   = '0;
            push_ra   = '0;
            push_rp   = '0;
          end
          hold_v_d = 1'b0;
          state_d  = rtbu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rtbu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtbu_pkg::ST_IDLE;
      op_q        <= rtbu_pkg::ACT_ADD;
      idx_q       <= '0;
      valid_q     <= '0;
      timer_on_q  <= '0;
      occ_q       <= '0;
      resend_en_q <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      timer_on_q  <= timer_on_d;
      occ_q       <= occ_d;
      resend_en_q <= resend_en_d;
      hold_v_q    <= hold_v_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= rtbu_pkg::entry_t'(s_axis_tdata_i[ENTRY_W-1:0]);
    end
    hold_kind_q <= hold_kind_d;
    hold_pkt_q  <= hold_pkt_d;
    hold_nk_q   <= hold_nk_d;
    hold_ra_q   <= hold_ra_d;
    hold_rp_q   <= hold_rp_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_pkt_q  <= push_pkt;
      out_nk_q   <= push_nk;
      out_ra_q   <= push_ra;
      out_rp_q   <= push_rp;
      out_occ_q  <= occ_d;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_W - 68 - OCC_W){1'b0}}, out_occ_q, out_rp_q,
                            out_ra_q, out_nk_q, out_pkt_q};

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_W'($countones(valid_q)))
    else $error("occupancy count differs from the number of valid entries");

  a_timer_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_on_q & ~valid_q) == '0)
    else $error("timer running on an empty slot");

  a_hold_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtbu_pkg::ST_IDLE) |-> !hold_v_q)
    else $error("held result left over while idle");
`endif

endmodule

// ----- src/rtbu_ram.sv -----
// ----------------------------------------------------------------------------
// rtbu_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rtbu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rtbu_cfg.sv -----
// ----------------------------------------------------------------------------
// rtbu_cfg
// Register file of the five backoff delays behind the configuration port.
// ----------------------------------------------------------------------------
module rtbu_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output rtbu_pkg::delays_t delays_o
);

  rtbu_pkg::delays_t delays_q;
  logic [2:0]        idx;
  logic              wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delays_q[0] <= 8'd2;
      delays_q[1] <= 8'd2;
      delays_q[2] <= 8'd4;
      delays_q[3] <= 8'd4;
      delays_q[4] <= 8'd8;
    end else if (wr_en) begin
      case (idx)
        rtbu_pkg::REG_DELAY_FIRST:  delays_q[0] <= pwdata[7:0];
        rtbu_pkg::REG_DELAY_SECOND: delays_q[1] <= pwdata[7:0];
        rtbu_pkg::REG_DELAY_THIRD:  delays_q[2] <= pwdata[7:0];
        rtbu_pkg::REG_DELAY_FOURTH: delays_q[3] <= pwdata[7:0];
        rtbu_pkg::REG_DELAY_FIFTH:  delays_q[4] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      rtbu_pkg::REG_DELAY_FIRST:  prdata = {24'd0, delays_q[0]};
      rtbu_pkg::REG_DELAY_SECOND: prdata = {24'd0, delays_q[1]};
      rtbu_pkg::REG_DELAY_THIRD:  prdata = {24'd0, delays_q[2]};
      rtbu_pkg::REG_DELAY_FOURTH: prdata = {24'd0, delays_q[3]};
      rtbu_pkg::REG_DELAY_FIFTH:  prdata = {24'd0, delays_q[4]};
      default:                    prdata = '0;
    endcase
  end

  assign delays_o = delays_q;

endmodule

// ----- tb/retransmit_table_with_backoff_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_table_with_backoff_unit_tb
// Self-checking testbench of the retransmission table with backoff.
// Directed transactions cover empty-table answers, extreme field values,
// duplicate adds, a full table, resends up to give-up and zero delays.
// Random phases follow with different delay settings and different amounts of
// source idling and sink back-pressure. A model in the bench predicts every
// result transaction, which the sink process compares field by field.
// ----------------------------------------------------------------------------
module retransmit_table_with_backoff_unit_tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned OUT_W = 80;
  // Action codes that the block ignores.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  // Longest walk of the table, with some margin.
  localparam int unsigned WALK_CYCLES = 2 * DEPTH + 12;
  localparam int unsigned ID_POOL = 24;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] uid_addr;
    logic [63:0] uid_time;
    logic [3:0]  kind;
    logic [31:0] reply_addr;
    logic [15:0] reply_port;
    logic [15:0] packet;
  } msg_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] packet;
    logic [3:0]  notice;
    logic [31:0] reply_addr;
    logic [15:0] reply_port;
    logic [4:0]  occupancy;
    logic        last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [rtbu_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [rtbu_pkg::ACTION_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic [rtbu_pkg::RESULT_W-1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  retransmit_table_with_backoff_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Bench copy of the table and of the delay registers.
  logic [rtbu_pkg::DELAY_W-1:0] backoff [rtbu_pkg::DELAY_COUNT];
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_uid_addr [DEPTH];
  logic [63:0] tbl_uid_time [DEPTH];
  logic [3:0]  tbl_kind [DEPTH];
  logic [31:0] tbl_reply_addr [DEPTH];
  logic [15:0] tbl_reply_port [DEPTH];
  logic [15:0] tbl_packet [DEPTH];
  logic        tbl_timer_on [DEPTH];
  logic [7:0]  tbl_ticks [DEPTH];
  logic [2:0]  tbl_retries [DEPTH];
  logic        resend_on;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] pool_addr [ID_POOL];
  logic [63:0] pool_time [ID_POOL];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // Adds one answer of the current step to the expectation queue.
  function automatic void push_answer(logic [2:0] k, logic [15:0] pkt, logic [3:0] nk,
                                      logic [31:0] ra, logic [15:0] rp);
    answer_t a;
    a.kind = k;
    a.packet = pkt;
    a.notice = nk;
    a.reply_addr = ra;
    a.reply_port = rp;
    a.occupancy = '0;
    a.last = 1'b0;
    pending_answers.push_back(a);
  endfunction

  // Updates the bench table for one accepted transaction and queues its answers.
  function automatic void predict_table_step(msg_t m);
    int first;
    int slot;
    int occ;
    first = pending_answers.size();
    slot = -1;
    occ = 0;
    case (m.act)
      rtbu_pkg::ACT_ADD, rtbu_pkg::ACT_REMOVE: begin
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && tbl_valid[i] && tbl_uid_addr[i] == m.uid_addr &&
              tbl_uid_time[i] == m.uid_time)
            slot = i;
        if (m.act == rtbu_pkg::ACT_REMOVE) begin
          if (slot < 0) begin
            push_answer(rtbu_pkg::RES_NOTFOUND, '0, '0, '0, '0);
          end else begin
            push_answer(rtbu_pkg::RES_OK, '0, tbl_kind[slot], tbl_reply_addr[slot],
                        tbl_reply_port[slot]);
            tbl_valid[slot] = 1'b0;
            tbl_timer_on[slot] = 1'b0;
          end
        end else if (slot >= 0) begin
          // A duplicate id leaves the table untouched.
          push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
        end else begin
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            push_answer(rtbu_pkg::RES_FULL, '0, '0, '0, '0);
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_uid_addr[slot] = m.uid_addr;
            tbl_uid_time[slot] = m.uid_time;
            tbl_kind[slot] = m.kind;
            tbl_reply_addr[slot] = m.reply_addr;
            tbl_reply_port[slot] = m.reply_port;
            tbl_packet[slot] = m.packet;
            tbl_retries[slot] = '0;
            tbl_ticks[slot] = backoff[0];
            tbl_timer_on[slot] = resend_on;
            push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
          end
        end
      end
      rtbu_pkg::ACT_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_timer_on[i]) begin
            // A timer loaded with zero behaves as if loaded with one.
            if (tbl_ticks[i] > 8'd1) begin
              tbl_ticks[i]--;
            end else begin
              tbl_retries[i] = tbl_retries[i] + 3'd1;
              if (tbl_retries[i] >= rtbu_pkg::RETRY_LIMIT) begin
                tbl_timer_on[i] = 1'b0;
                push_answer(rtbu_pkg::RES_GIVEUP, tbl_packet[i], '0, '0, '0);
              end else begin
                tbl_ticks[i] = backoff[tbl_retries[i]];
                push_answer(rtbu_pkg::RES_RESEND, tbl_packet[i], '0, '0, '0);
              end
            end
          end
        end
        if (pending_answers.size() == first) push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
      end
      rtbu_pkg::ACT_FOUND: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) begin
            tbl_timer_on[i] = 1'b1;
            tbl_ticks[i] = backoff[0];
            tbl_retries[i] = '0;
            push_answer(rtbu_pkg::RES_RESEND, tbl_packet[i], '0, '0, '0);
          end
        end
        resend_on = 1'b1;
        if (pending_answers.size() == first) push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
      end
      rtbu_pkg::ACT_LOST: begin
        for (int i = 0; i < DEPTH; i++) tbl_timer_on[i] = 1'b0;
        resend_on = 1'b0;
        push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
      end
      rtbu_pkg::ACT_FLUSH: begin
        // Flush keeps the resend enable as it is.
        for (int i = 0; i < DEPTH; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_timer_on[i] = 1'b0;
        end
        push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
      end
      default: push_answer(rtbu_pkg::RES_OK, '0, '0, '0, '0);
    endcase
    for (int i = 0; i < DEPTH; i++) occ += tbl_valid[i];
    for (int i = first; i < pending_answers.size(); i++)
      pending_answers[i].occupancy = 5'(occ);
    pending_answers[pending_answers.size() - 1].last = 1'b1;
  endfunction

  // Sink: random back-pressure and comparison of every result transaction.
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction: kind %0d", m_axis_tuser_o);
        errors++;
      end else begin
        a = pending_answers.pop_front();
        if (m_axis_tuser_o !== a.kind) begin
          $error("result_kind: expected %0d, got %0d", a.kind, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[15:0] !== a.packet) begin
          $error("packet_ref_out: expected %h, got %h", a.packet, m_axis_tdata_o[15:0]);
          errors++;
        end
        if (m_axis_tdata_o[19:16] !== a.notice) begin
          $error("notice_kind_out: expected %h, got %h", a.notice, m_axis_tdata_o[19:16]);
          errors++;
        end
        if (m_axis_tdata_o[51:20] !== a.reply_addr) begin
          $error("reply_addr_out: expected %h, got %h", a.reply_addr,
                 m_axis_tdata_o[51:20]);
          errors++;
        end
        if (m_axis_tdata_o[67:52] !== a.reply_port) begin
          $error("reply_port_out: expected %h, got %h", a.reply_port,
                 m_axis_tdata_o[67:52]);
          errors++;
        end
        if (m_axis_tdata_o[72:68] !== a.occupancy) begin
          $error("occupancy: expected %0d, got %0d", a.occupancy, m_axis_tdata_o[72:68]);
          errors++;
        end
        if (m_axis_tlast_o !== a.last) begin
          $error("last: expected %0d, got %0d", a.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one transaction and returns at the edge where it is accepted.
  // tvalid stays high afterwards so back-to-back transactions need no gap.
  task automatic send_msg(msg_t m);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= m.act;
    s_axis_tdata_i <= {4'd0, m.packet, m.reply_port, m.reply_addr, m.kind,
                       m.uid_time, m.uid_addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_table_step(m);
  endtask

  task automatic send_simple(logic [2:0] act);
    msg_t m;
    m = '{act, 32'd0, 64'd0, 4'd0, 32'd0, 16'd0, 16'd0};
    send_msg(m);
  endtask

  // Waits until every expected result has arrived and the block is idle.
  task automatic drain(bit settle);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    if (settle) repeat (WALK_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_delay(logic [2:0] idx, logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    // The top byte is random; only the low byte belongs to the register.
    pwdata <= {8'($urandom_range(255)), 16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    backoff[idx] = value;
  endtask

  task automatic load_delays(logic [7:0] d0, logic [7:0] d1, logic [7:0] d2,
                             logic [7:0] d3, logic [7:0] d4);
    write_delay(rtbu_pkg::REG_DELAY_FIRST, d0);
    write_delay(rtbu_pkg::REG_DELAY_SECOND, d1);
    write_delay(rtbu_pkg::REG_DELAY_THIRD, d2);
    write_delay(rtbu_pkg::REG_DELAY_FOURTH, d3);
    write_delay(rtbu_pkg::REG_DELAY_FIFTH, d4);
  endtask

  // Empty-table answers, extreme field values, duplicates and spare actions.
  task automatic test_basic_actions();
    msg_t ones;
    msg_t zeros;
    ones = '{rtbu_pkg::ACT_ADD, '1, '1, '1, '1, '1, '1};
    zeros = '{rtbu_pkg::ACT_ADD, '0, '0, '0, '0, '0, '0};
    send_simple(rtbu_pkg::ACT_REMOVE);
    send_simple(rtbu_pkg::ACT_TICK);
    send_simple(rtbu_pkg::ACT_FOUND);
    send_msg(ones);
    send_msg(zeros);
    send_msg(ones);
    ones.act = rtbu_pkg::ACT_REMOVE;
    send_msg(ones);
    send_msg(ones);
    send_simple(ACT_SPARE_A);
    send_simple(ACT_SPARE_B);
    send_simple(rtbu_pkg::ACT_LOST);
    send_simple(rtbu_pkg::ACT_FLUSH);
    drain(1);
  endtask

  // Fills the table past full, then resends everything until all give up.
  // Zero delays expire on the very next tick.
  task automatic test_full_table_backoff();
    msg_t m;
    load_delays(8'd1, 8'd0, 8'd1, 8'd0, 8'd1);
    send_simple(rtbu_pkg::ACT_FOUND);
    for (int i = 0; i <= DEPTH; i++) begin
      m = '{rtbu_pkg::ACT_ADD, 32'(i), 64'(i) << 40, 4'(i), $urandom, 16'($urandom),
            16'($urandom)};
      send_msg(m);
    end
    send_simple(rtbu_pkg::ACT_FOUND);
    repeat (6) send_simple(rtbu_pkg::ACT_TICK);
    send_simple(rtbu_pkg::ACT_FLUSH);
    drain(1);
  endtask

  function automatic msg_t random_msg();
    msg_t m;
    int r;
    int p;
    r = $urandom_range(99);
    p = $urandom_range(ID_POOL - 1);
    m.uid_addr = pool_addr[p];
    m.uid_time = pool_time[p];
    m.kind = 4'($urandom);
    m.reply_addr = $urandom;
    m.reply_port = 16'($urandom);
    m.packet = 16'($urandom);
    if (r < 32) m.act = rtbu_pkg::ACT_ADD;
    else if (r < 52) m.act = rtbu_pkg::ACT_REMOVE;
    else if (r < 86) m.act = rtbu_pkg::ACT_TICK;
    else if (r < 92) m.act = rtbu_pkg::ACT_FOUND;
    else if (r < 95) m.act = rtbu_pkg::ACT_LOST;
    else if (r < 97) m.act = rtbu_pkg::ACT_FLUSH;
    else m.act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    // Occasionally an id that is almost surely absent.
    if ($urandom_range(9) == 0) begin
      m.uid_addr = $urandom;
      m.uid_time = {$urandom, $urandom};
    end
    return m;
  endfunction

  task automatic test_random_phase(int n_items, int idle, int stall, bit pause_once);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      send_msg(random_msg());
      // The source holds off once until everything outstanding has come back.
      if (pause_once && i == n_items / 2) drain(0);
    end
    drain(1);
  endtask

  initial begin
    resend_on = 1'b0;
    backoff = '{8'd2, 8'd2, 8'd4, 8'd4, 8'd8};
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_timer_on[i] = 1'b0;
    end
    for (int i = 0; i < ID_POOL; i++) begin
      pool_addr[i] = $urandom;
      pool_time[i] = {$urandom, $urandom};
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_actions();
    test_full_table_backoff();
    load_delays(8'd2, 8'd2, 8'd4, 8'd4, 8'd8);
    test_random_phase(120, 0, 0, 1'b1);
    load_delays(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    test_random_phase(120, 76, 0, 1'b0);
    load_delays(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_simple(rtbu_pkg::ACT_FOUND);
    test_random_phase(40, 0, 76, 1'b0);
    load_delays(8'(1 + $urandom_range(3)), 8'(1 + $urandom_range(3)),
                8'($urandom_range(3)), 8'(1 + $urandom_range(3)), 8'(1 + $urandom_range(3)));
    test_random_phase(80, 0, 76, 1'b0);
    load_delays(8'd1, 8'd255, 8'd0, 8'd2, 8'd3);
    test_random_phase(120, 8, 8, 1'b0);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
